// ===== hw/rtl/ksa_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ksa_pkg: shared types and constants for the keyed sample aggregator
// Mode codes, controller states and the command/status structs.
// ----------------------------------------------------------------------------
package ksa_pkg;

  localparam logic [1:0] MODE_ADD    = 2'd0;
  localparam logic [1:0] MODE_FLUSH  = 2'd1;
  localparam logic [1:0] MODE_CLEAR  = 2'd2;
  localparam logic [1:0] MODE_UNUSED = 2'd3;  // ignored by the block

  localparam int unsigned FILL_SHIFT = 2;  // weight / 4
  localparam int unsigned DIV_BITS   = 64;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_MERGE,
    ST_FSCAN,
    ST_FDIV_START,
    ST_FDIV,
    ST_FEMIT,
    ST_FEMPTY
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic load;        // capture input word
    logic scan_clr;    // reset scan index and best tracking
    logic scan_step;   // compare one entry, advance index
    logic merge;       // write merged/allocated entry
    logic drop;        // set sticky overflow
    logic clear;       // empty table
    logic div_start;   // latch best entry, start divider
    logic div_step;    // one restoring division step
    logic emit;        // drive result for one cycle
    logic emit_empty;  // drive empty-table result
    logic next_rank;   // record emitted key as previous
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic scan_done;   // index reached used count
    logic hit;         // search found the key
    logic full;        // table full
    logic empty;       // used count is zero
    logic div_done;    // divider finished
    logic last_rank;   // emitted entry is the final one
  } status_t;

endpackage

// ===== hw/rtl/ksa_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ksa_ctrl: sequencer for the keyed sample aggregator
// Steps add searches, flush ranking scans and the per-entry divider; issues clears.
// ----------------------------------------------------------------------------
module ksa_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [1:0]        mode,
  output logic              busy,
  output ksa_pkg::cmd_t     cmd,
  input  ksa_pkg::status_t  stat
);

  ksa_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= ksa_pkg::ST_IDLE;
    else     state <= state_next;
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ksa_pkg::ST_IDLE: begin
        if (start) begin
          if (mode == ksa_pkg::MODE_ADD)        state_next = ksa_pkg::ST_SEARCH;
          else if (mode == ksa_pkg::MODE_FLUSH) state_next = ksa_pkg::ST_FSCAN;
        end
      end
      ksa_pkg::ST_SEARCH: begin
        if (stat.hit || stat.scan_done) state_next = ksa_pkg::ST_MERGE;
      end
      ksa_pkg::ST_MERGE: state_next = ksa_pkg::ST_IDLE;
      ksa_pkg::ST_FSCAN: begin
        if (stat.empty)          state_next = ksa_pkg::ST_FEMPTY;
        else if (stat.scan_done) state_next = ksa_pkg::ST_FDIV_START;
      end
      ksa_pkg::ST_FDIV_START: state_next = ksa_pkg::ST_FDIV;
      ksa_pkg::ST_FDIV: begin
        if (stat.div_done) state_next = ksa_pkg::ST_FEMIT;
      end
      ksa_pkg::ST_FEMIT: begin
        state_next = stat.last_rank ? ksa_pkg::ST_IDLE : ksa_pkg::ST_FSCAN;
      end
      ksa_pkg::ST_FEMPTY: state_next = ksa_pkg::ST_IDLE;
      default: state_next = ksa_pkg::ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd  = '0;
    busy = (state != ksa_pkg::ST_IDLE);
    unique case (state)
      ksa_pkg::ST_IDLE: begin
        cmd.load     = start;
        cmd.scan_clr = start;
        cmd.clear    = start && (mode == ksa_pkg::MODE_CLEAR);
      end
      ksa_pkg::ST_SEARCH: begin
        cmd.scan_step = !(stat.hit || stat.scan_done);
      end
      ksa_pkg::ST_MERGE: begin
        cmd.merge = stat.hit || !stat.full;
        cmd.drop  = !stat.hit && stat.full;
      end
      ksa_pkg::ST_FSCAN: begin
        cmd.scan_step = !stat.empty && !stat.scan_done;
      end
      ksa_pkg::ST_FDIV_START: cmd.div_start = 1'b1;
      ksa_pkg::ST_FDIV:       cmd.div_step  = !stat.div_done;
      ksa_pkg::ST_FEMIT: begin
        cmd.emit      = 1'b1;
        cmd.next_rank = 1'b1;
        cmd.scan_clr  = 1'b1;
      end
      ksa_pkg::ST_FEMPTY: cmd.emit_empty = 1'b1;
      default: ;
    endcase
  end

  a_emit_busy: assert property (@(posedge clk) disable iff (rst)
    (cmd.emit || cmd.emit_empty) |-> busy) else $error("emit while idle");
  a_merge_after_search: assert property (@(posedge clk) disable iff (rst)
    (state == ksa_pkg::ST_MERGE) |-> $past(state) == ksa_pkg::ST_SEARCH)
    else $error("merge without search");
  a_one_result_kind: assert property (@(posedge clk) disable iff (rst)
    !(cmd.emit && cmd.emit_empty)) else $error("two result kinds");

endmodule

// ===== hw/rtl/ksa_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ksa_datapath: entry table, key scan and result divider
// One entry compared per cycle; quotient built one bit per cycle.
// ----------------------------------------------------------------------------
module ksa_datapath #(
  parameter int unsigned MAX_STREAMS = 16,
  parameter int unsigned IDX_W       = (MAX_STREAMS > 1) ? $clog2(MAX_STREAMS) : 1,
  parameter int unsigned CNT_W       = $clog2(MAX_STREAMS + 1)
) (
  input  logic              clk,
  input  logic              rst,
  input  ksa_pkg::cmd_t     cmd,
  output ksa_pkg::status_t  stat,
  input  logic [63:0]       sample_key,
  input  logic [15:0]       sample_average,
  input  logic [15:0]       sample_min,
  input  logic [15:0]       sample_max,
  input  logic [15:0]       sample_fill,
  output logic              valid,
  output logic [63:0]       out_stream_id,
  output logic [4:0]        entry_count,
  output logic              entry_present,
  output logic [15:0]       out_average,
  output logic [15:0]       out_min,
  output logic [15:0]       out_max,
  output logic [15:0]       out_fill,
  output logic              overflow,
  output logic              last
);

  localparam int unsigned DB = ksa_pkg::DIV_BITS;
  localparam int unsigned DC_W = $clog2(DB + 1);

  // entry table, kept in registers: read at the scan index, merge slot and best entry
  logic [63:0] key_mem    [MAX_STREAMS];
  logic [63:0] total_mem  [MAX_STREAMS];
  logic [31:0] weight_mem [MAX_STREAMS];
  logic [15:0] min_mem    [MAX_STREAMS];
  logic [15:0] max_mem    [MAX_STREAMS];

  logic [CNT_W-1:0] used;
  logic             dropped;

  // captured input word
  logic [63:0] in_key;
  logic [15:0] in_avg, in_min, in_max, in_fill;

  // scan state
  logic [CNT_W-1:0] idx;
  logic             hit;
  logic [IDX_W-1:0] best;
  logic             found;
  logic [63:0]      prev;
  logic             have_prev;
  logic [CNT_W-1:0] rank;

  // divider
  logic [63:0]      dq;      // dividend shifting into quotient
  logic [32:0]      drem;
  logic [31:0]      dden;
  logic [DC_W-1:0]  dcnt;
  logic [63:0]      r_key;
  logic [15:0]      r_min, r_max, r_fill;

  logic [IDX_W-1:0] cur;
  assign cur  = idx[IDX_W-1:0];

  assign stat.scan_done = (idx == used);
  assign stat.hit       = hit;
  assign stat.full      = (used == CNT_W'(MAX_STREAMS));
  assign stat.empty     = (used == '0);
  assign stat.div_done  = (dcnt == DC_W'(DB));
  assign stat.last_rank = (rank + CNT_W'(1) == used);

  // capture input word
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      in_key  <= sample_key;
      in_avg  <= sample_average;
      in_min  <= sample_min;
      in_max  <= sample_max;
      in_fill <= sample_fill;
    end
  end

  // scan over stored entries: key search for add, next-rank search for flush
  logic cand;
  assign cand = (!have_prev || key_mem[cur] > prev) &&
                (!found || key_mem[cur] < key_mem[best]);

  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= '0; hit <= 1'b0; found <= 1'b0; best <= '0;
    end else if (cmd.scan_clr) begin
      idx <= '0; hit <= 1'b0; found <= 1'b0; best <= '0;
    end else if (cmd.scan_step) begin
      idx <= idx + CNT_W'(1);
      if (key_mem[cur] == in_key) hit <= 1'b1;
      if (cand) begin
        best  <= cur;
        found <= 1'b1;
      end
    end
  end

  // for add search, merge must use the hit entry
  // (cand also updates best, so latch hit index separately)
  logic [IDX_W-1:0] hit_idx;
  always_ff @(posedge clk) begin
    if (cmd.scan_step && key_mem[cur] == in_key) hit_idx <= cur;
  end

  // merge sample into entry
  logic [63:0] base_total;
  logic [31:0] base_weight;
  logic [15:0] base_min, base_max;
  logic [31:0] prod;
  logic [64:0] tsum;
  logic [32:0] wsum;
  logic [IDX_W-1:0] wslot;
  assign wslot       = hit ? hit_idx : used[IDX_W-1:0];
  assign base_total  = hit ? total_mem[wslot]  : 64'd0;
  assign base_weight = hit ? weight_mem[wslot] : 32'd0;
  assign base_min    = hit ? min_mem[wslot]    : 16'hFFFF;
  assign base_max    = hit ? max_mem[wslot]    : 16'h0000;
  assign prod        = in_avg * in_fill;
  assign tsum        = {1'b0, base_total} + {33'd0, prod};
  assign wsum        = {1'b0, base_weight} + {17'd0, in_fill};

  always_ff @(posedge clk) begin
    if (cmd.merge) begin
      key_mem[wslot]    <= in_key;
      total_mem[wslot]  <= tsum[64] ? '1 : tsum[63:0];
      weight_mem[wslot] <= wsum[32] ? '1 : wsum[31:0];
      min_mem[wslot]    <= (in_min < base_min) ? in_min : base_min;
      max_mem[wslot]    <= (in_max > base_max) ? in_max : base_max;
    end
  end

  // occupancy, overflow flag and ranking progress
  always_ff @(posedge clk) begin
    if (rst) begin
      used <= '0; dropped <= 1'b0; rank <= '0; have_prev <= 1'b0; prev <= '0;
    end else begin
      if (cmd.clear) used <= '0;
      else if (cmd.merge && !hit) used <= used + CNT_W'(1);
      if (cmd.drop) dropped <= 1'b1;
      if (cmd.load) begin
        rank <= '0; have_prev <= 1'b0;
      end else if (cmd.next_rank) begin
        rank <= rank + CNT_W'(1); have_prev <= 1'b1; prev <= r_key;
      end
    end
  end

  // restoring divider, one quotient bit a cycle
  logic [32:0] trial;
  assign trial = {drem[31:0], dq[63]};
  always_ff @(posedge clk) begin
    if (rst) begin
      dcnt <= '0;
    end else if (cmd.div_start) begin
      dq     <= total_mem[best];
      dden   <= weight_mem[best];
      drem   <= '0;
      dcnt   <= '0;
      r_key  <= key_mem[best];
      r_min  <= min_mem[best];
      r_max  <= max_mem[best];
      r_fill <= 16'(weight_mem[best] >> ksa_pkg::FILL_SHIFT);
    end else if (cmd.div_step) begin
      dcnt <= dcnt + DC_W'(1);
      if (trial >= {1'b0, dden}) begin
        drem <= trial - {1'b0, dden};
        dq   <= {dq[62:0], 1'b1};
      end else begin
        drem <= trial;
        dq   <= {dq[62:0], 1'b0};
      end
    end
  end

  // result word
  logic [15:0] avg_sat;
  assign avg_sat = (dden == '0) ? 16'd0 :
                   (dq[63:16] != '0) ? 16'hFFFF : dq[15:0];

  always_comb begin
    valid         = cmd.emit || cmd.emit_empty;
    overflow      = dropped;
    entry_count   = 5'(used);
    entry_present = cmd.emit;
    last          = cmd.emit_empty || stat.last_rank;
    out_stream_id = cmd.emit ? r_key   : 64'd0;
    out_average   = cmd.emit ? avg_sat : 16'd0;
    out_min       = cmd.emit ? r_min   : 16'd0;
    out_max       = cmd.emit ? r_max   : 16'd0;
    out_fill      = cmd.emit ? r_fill  : 16'd0;
  end

  a_used_bound: assert property (@(posedge clk) disable iff (rst)
    used <= CNT_W'(MAX_STREAMS)) else $error("used count past depth");
  a_drop_sticky: assert property (@(posedge clk) disable iff (rst)
    $past(dropped) && !$past(rst) |-> dropped) else $error("overflow cleared");
  a_no_merge_full: assert property (@(posedge clk) disable iff (rst)
    cmd.merge && !hit |-> !stat.full) else $error("alloc into full table");

endmodule

// ===== hw/rtl/keyed_sample_aggregator.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// keyed_sample_aggregator: per-stream sample accumulator with ordered flush
// Add: load, search (k entries compared before hit or end, k <= used), merge.
// Flush: per entry, a scan of the used entries, the divider, then one emit.
// Clear: done in idle. One item at a time; results cannot be stalled.
// Synchronous reset empties the table and clears overflow; entries need none.
// ----------------------------------------------------------------------------
module keyed_sample_aggregator #(
  parameter int unsigned MAX_STREAMS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  mode,
  input  logic [63:0] sample_key,
  input  logic [15:0] sample_average,
  input  logic [15:0] sample_min,
  input  logic [15:0] sample_max,
  input  logic [15:0] sample_fill,
  output logic        valid,
  output logic [63:0] out_stream_id,
  output logic [4:0]  entry_count,
  output logic        entry_present,
  output logic [15:0] out_average,
  output logic [15:0] out_min,
  output logic [15:0] out_max,
  output logic [15:0] out_fill,
  output logic        overflow,
  output logic        last
);

  ksa_pkg::cmd_t    cmd;
  ksa_pkg::status_t stat;

  ksa_ctrl u_ctrl (
    .clk(clk), .rst(rst), .start(start), .mode(mode),
    .busy(busy), .cmd(cmd), .stat(stat)
  );

  ksa_datapath #(.MAX_STREAMS(MAX_STREAMS)) u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .stat(stat),
    .sample_key(sample_key), .sample_average(sample_average),
    .sample_min(sample_min), .sample_max(sample_max), .sample_fill(sample_fill),
    .valid(valid), .out_stream_id(out_stream_id), .entry_count(entry_count),
    .entry_present(entry_present), .out_average(out_average),
    .out_min(out_min), .out_max(out_max), .out_fill(out_fill),
    .overflow(overflow), .last(last)
  );

endmodule
